### src/shot_cycle_sequencer_defines.svh
// ----------------------------------------------------------------------------
// shot cycle sequencer assertion macros
// shared concurrent assertion wrappers, clocked on i_clk; SCS_ASSERT is gated by i_rst_n
// ----------------------------------------------------------------------------
`ifndef SHOT_CYCLE_SEQUENCER_DEFINES_SVH
`define SHOT_CYCLE_SEQUENCER_DEFINES_SVH

// property checked only outside reset
`define SCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define SCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// types, constants and helpers of the shot cycle sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [3:0]  SHOTS_PER_BATCH  = 4'd4;
    localparam logic [31:0] TIMEOUT_EXTRA_MS = 32'd1000;
    localparam logic [1:0]  SW_ON            = 2'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTER_SHOT    = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CHARGE  = 3'd1,
        PH_RELEASE = 3'd2,
        PH_PAUSE   = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef struct packed {
        logic signed [31:0] charge_left_target;
        logic signed [31:0] charge_right_target;
        logic signed [31:0] release_left_target;
        logic signed [31:0] release_right_target;
        logic [30:0]        angle_dead_zone;
        logic [15:0]        charge_hold_ms;
        logic [15:0]        release_hold_ms;
        logic [15:0]        inter_shot_ms;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  shot_count;
        logic [31:0] phase_start_ms;
        logic        armed;
        logic        trigger_pos;
    } t_state;

    typedef struct packed {
        logic               link_valid;
        logic [1:0]         enable_switch;
        logic [31:0]        now_ms;
        logic signed [31:0] left_angle;
        logic signed [31:0] right_angle;
    } t_item;

    typedef struct packed {
        logic               drive_active;
        logic signed [31:0] left_goal;
        logic signed [31:0] right_goal;
        logic               trigger_fire;
        logic               led_toggle;
        logic [2:0]         phase_code;
        logic [3:0]         shots_done;
    } t_result;

    // |angle - goal| <= dead zone, exact over 33 bits
    function automatic logic near_goal(
        input logic [31:0] angle,
        input logic [31:0] goal,
        input logic [30:0] dz
    );
        logic [32:0] diff;
        logic [32:0] mag;
        diff = {angle[31], angle} - {goal[31], goal};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
        return mag <= {2'b00, dz};
    endfunction

endpackage

`default_nettype wire

### src/scs_tick_if.sv
// ----------------------------------------------------------------------------
// scs_tick_if
// control tick channel: valid/ready handshake with the tick fields
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_tick_if;
    logic               valid;
    logic               ready;
    logic               link_valid;
    logic [1:0]         enable_switch;
    logic [31:0]        now_ms;
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle;

    modport source (
        output valid, link_valid, enable_switch, now_ms, left_angle, right_angle,
        input  ready
    );
    modport sink (
        input  valid, link_valid, enable_switch, now_ms, left_angle, right_angle,
        output ready
    );
endinterface

`default_nettype wire

### src/scs_result_if.sv
// ----------------------------------------------------------------------------
// scs_result_if
// result channel: valid/ready handshake with the sequencer outputs
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_result_if;
    logic               valid;
    logic               ready;
    logic               drive_active;
    logic signed [31:0] left_goal;
    logic signed [31:0] right_goal;
    logic               trigger_fire;
    logic               led_toggle;
    logic [2:0]         phase_code;
    logic [3:0]         shots_done;

    modport source (
        output valid, drive_active, left_goal, right_goal, trigger_fire,
               led_toggle, phase_code, shots_done,
        input  ready
    );
    modport sink (
        input  valid, drive_active, left_goal, right_goal, trigger_fire,
               led_toggle, phase_code, shots_done,
        output ready
    );
endinterface

`default_nettype wire

### src/shot_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// shot_cycle_sequencer
// sequences a batch of shots: charge, fire, release, pause, per control tick
// ----------------------------------------------------------------------------
// Usage:
//   i_tick carries one control tick per beat (link flag, switch, ms time and
//   both motor angles); o_res returns exactly one result beat per tick with
//   the motor goals, trigger position, led pulse, phase and shot count.
//   Targets, dead zone and hold times are written on the i_cfg_* port while
//   no tick is in flight; index i selects register i, one write per edge.
// Timing:
//   a tick is captured in the input register, its result is computed from it
//   and captured in the output register when the tick advances, which raises
//   o_res.valid; a stalled receiver can hold the tick in the input register.
//   One tick per cycle is sustained while the receiver is ready; the input
//   and output registers both hold a beat, so a stalled receiver only stops
//   intake once both are full.
// Reset:
//   i_rst_n low clears both beat registers, puts the sequencer in idle with
//   no batch armed and the trigger stored, and loads the register defaults.
//   A switch already on at reset does not start a batch: it must go off and
//   on again first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shot_cycle_sequencer_defines.svh"

module shot_cycle_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    scs_tick_if.sink                            i_tick,
    scs_result_if.source                        o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [scs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [scs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scs_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    advance;
    logic    in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_left_target   <= '0;
            r_cfg.charge_right_target  <= '0;
            r_cfg.release_left_target  <= '0;
            r_cfg.release_right_target <= '0;
            r_cfg.angle_dead_zone      <= 31'd256;
            r_cfg.charge_hold_ms       <= 16'd500;
            r_cfg.release_hold_ms      <= 16'd500;
            r_cfg.inter_shot_ms        <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHARGE_LEFT:   r_cfg.charge_left_target   <= i_cfg_data;
                CFG_CHARGE_RIGHT:  r_cfg.charge_right_target  <= i_cfg_data;
                CFG_RELEASE_LEFT:  r_cfg.release_left_target  <= i_cfg_data;
                CFG_RELEASE_RIGHT: r_cfg.release_right_target <= i_cfg_data;
                CFG_DEAD_ZONE:     r_cfg.angle_dead_zone      <= i_cfg_data[30:0];
                CFG_CHARGE_HOLD:   r_cfg.charge_hold_ms       <= i_cfg_data[15:0];
                CFG_RELEASE_HOLD:  r_cfg.release_hold_ms      <= i_cfg_data[15:0];
                CFG_INTER_SHOT:    r_cfg.inter_shot_ms        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // a tick moves on when the result slot is free or being emptied
    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || advance;
    assign in_take      = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.link_valid    <= i_tick.link_valid;
            r_in.enable_switch <= i_tick.enable_switch;
            r_in.now_ms        <= i_tick.now_ms;
            r_in.left_angle    <= i_tick.left_angle;
            r_in.right_angle   <= i_tick.right_angle;
        end
    end

    scs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.shot_count     <= '0;
            r_state.phase_start_ms <= '0;
            r_state.armed          <= 1'b0;
            r_state.trigger_pos    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.drive_active = r_out.drive_active;
    assign o_res.left_goal    = r_out.left_goal;
    assign o_res.right_goal   = r_out.right_goal;
    assign o_res.trigger_fire = r_out.trigger_fire;
    assign o_res.led_toggle   = r_out.led_toggle;
    assign o_res.phase_code   = r_out.phase_code;
    assign o_res.shots_done   = r_out.shots_done;

    // a fire pulse always lands with the trigger out and the release phase
    `SCS_ASSERT(a_fire_release,
        (r_out_valid && r_out.led_toggle) |->
        (r_out.trigger_fire && r_out.phase_code == PH_RELEASE),
        "fire pulse without trigger out in release")
    // the shot count never passes the batch size, and done means a full batch
    `SCS_ASSERT(a_count_range,
        (r_state.shot_count <= SHOTS_PER_BATCH) &&
        ((r_state.phase != PH_DONE) || (r_state.shot_count == SHOTS_PER_BATCH)),
        "shot count out of range for phase")
    // sequencer state only moves when a tick is consumed
    `SCS_ASSERT(a_state_hold,
        !advance |=> $stable(r_state),
        "sequencer state changed without a tick")
    // a tick waiting in the input register with a stalled result stays parked
    `SCS_ASSERT(a_stall_park,
        (r_in_valid && r_out_valid && !o_res.ready) |=> (r_in_valid && r_out_valid),
        "beat dropped under output stall")

endmodule

`default_nettype wire

### src/scs_step.sv
// ----------------------------------------------------------------------------
// scs_step
// next-state and result logic for one control tick
// ----------------------------------------------------------------------------
`default_nettype none

module scs_step (
    input  scs_pkg::t_cfg    i_cfg,
    input  scs_pkg::t_state  i_state,
    input  scs_pkg::t_item   i_item,
    output scs_pkg::t_state  o_state,
    output scs_pkg::t_result o_result
);
    import scs_pkg::*;

    logic               allowed;
    logic [31:0]        elapsed;
    logic               in_charge;
    logic signed [31:0] goal_l;
    logic signed [31:0] goal_r;
    logic [15:0]        hold_ms;
    logic               reached;
    logic               hold_ok;
    logic               timed_out;
    logic               pause_ok;
    logic [3:0]         count_inc;

    assign allowed   = i_item.link_valid && (i_item.enable_switch == SW_ON);
    assign elapsed   = i_item.now_ms - i_state.phase_start_ms;
    assign in_charge = (i_state.phase == PH_CHARGE);

    // charge drives the charge targets, release and pause the release targets
    assign goal_l  = in_charge ? i_cfg.charge_left_target  : i_cfg.release_left_target;
    assign goal_r  = in_charge ? i_cfg.charge_right_target : i_cfg.release_right_target;
    assign hold_ms = in_charge ? i_cfg.charge_hold_ms      : i_cfg.release_hold_ms;

    assign reached   = near_goal(i_item.left_angle, goal_l, i_cfg.angle_dead_zone)
                    && near_goal(i_item.right_angle, goal_r, i_cfg.angle_dead_zone);
    assign hold_ok   = elapsed >= {16'd0, hold_ms};
    assign timed_out = elapsed >= ({16'd0, hold_ms} + TIMEOUT_EXTRA_MS);
    assign pause_ok  = elapsed >= {16'd0, i_cfg.inter_shot_ms};
    assign count_inc = i_state.shot_count + 4'd1;

    always_comb begin
        o_state               = i_state;
        o_result.drive_active = 1'b0;
        o_result.left_goal    = '0;
        o_result.right_goal   = '0;
        o_result.led_toggle   = 1'b0;

        if (!allowed) begin
            o_state.phase       = PH_IDLE;
            o_state.shot_count  = '0;
            o_state.armed       = 1'b1;
            o_state.trigger_pos = 1'b0;
        end else begin
            unique case (i_state.phase)
                PH_IDLE: begin
                    if (i_state.armed) begin
                        o_state.phase          = PH_CHARGE;
                        o_state.shot_count     = '0;
                        o_state.armed          = 1'b0;
                        o_state.phase_start_ms = i_item.now_ms;
                        o_state.trigger_pos    = 1'b0;
                    end
                end
                PH_CHARGE: begin
                    o_result.drive_active = 1'b1;
                    o_result.left_goal    = goal_l;
                    o_result.right_goal   = goal_r;
                    if ((reached && hold_ok) || timed_out) begin
                        o_state.trigger_pos    = 1'b1;
                        o_result.led_toggle    = 1'b1;
                        o_state.phase          = PH_RELEASE;
                        o_state.phase_start_ms = i_item.now_ms;
                    end
                end
                PH_RELEASE: begin
                    o_result.drive_active = 1'b1;
                    o_result.left_goal    = goal_l;
                    o_result.right_goal   = goal_r;
                    if ((reached && hold_ok) || timed_out) begin
                        o_state.trigger_pos    = 1'b0;
                        o_state.shot_count     = count_inc;
                        o_state.phase_start_ms = i_item.now_ms;
                        if (count_inc >= SHOTS_PER_BATCH) begin
                            o_state.phase = PH_DONE;
                            o_state.armed = 1'b0;
                        end else begin
                            o_state.phase = PH_PAUSE;
                        end
                    end
                end
                PH_PAUSE: begin
                    o_result.drive_active = 1'b1;
                    o_result.left_goal    = goal_l;
                    o_result.right_goal   = goal_r;
                    if (pause_ok) begin
                        o_state.phase          = PH_CHARGE;
                        o_state.phase_start_ms = i_item.now_ms;
                    end
                end
                default: begin
                    // batch done: wait for the switch to cycle
                end
            endcase
        end

        o_result.trigger_fire = o_state.trigger_pos;
        o_result.phase_code   = o_state.phase;
        o_result.shots_done   = o_state.shot_count;
    end

endmodule

`default_nettype wire
